>>> design/ptrt_pkg.sv
// periodic task release timer: shared types, constants and the control-store program
// no dependencies; imported by periodic_task_release_timer
`default_nettype none

package ptrt_pkg;

    localparam int TASKS      = 8;
    localparam int PASS_LIMIT = 16;

    localparam int SLOT_W = (TASKS > 1) ? $clog2(TASKS) : 1;
    localparam int PASS_W = $clog2(PASS_LIMIT + 1);
    localparam int PC_W   = 4;

    // stream word widths, padded to whole bytes
    localparam int IN_W  = 72;
    localparam int OUT_W = 48;

    localparam logic [15:0] NO_COMPARE = 16'hFFFF;
    localparam int          TRIG_POS   = 7;

    typedef enum logic [1:0] {
        OP_REGISTER   = 2'd0,
        OP_UNREGISTER = 2'd1,
        OP_TIMER      = 2'd2,
        OP_READ       = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BOUNDS = 2'd1,
        ST_PARAM  = 2'd2,
        ST_BUSY   = 2'd3
    } status_t;

    // datapath action of one control word
    typedef enum logic [3:0] {
        A_NONE,
        A_REG,
        A_UNREG,
        A_READ,
        A_TINIT,
        A_PSTART,
        A_SLOT,
        A_OVF,
        A_SHOW
    } act_t;

    // sequencing of one control word
    typedef enum logic [2:0] {
        J_NEXT,
        J_GOTO,
        J_DISPATCH,
        J_CMP_GT,
        J_PASS_LIM,
        J_SLOT_LOOP,
        J_NO_CMP,
        J_OUT
    } jmp_t;

    typedef struct packed {
        act_t             act;
        jmp_t             jmp;
        logic [PC_W-1:0]  target;
    } ucode_t;

    // program addresses
    localparam logic [PC_W-1:0] P_IDLE   = 4'd0;
    localparam logic [PC_W-1:0] P_REG    = 4'd1;
    localparam logic [PC_W-1:0] P_UNREG  = 4'd2;
    localparam logic [PC_W-1:0] P_TIMER  = 4'd3;
    localparam logic [PC_W-1:0] P_READ   = 4'd4;
    localparam logic [PC_W-1:0] P_PTEST  = 4'd5;
    localparam logic [PC_W-1:0] P_LTEST  = 4'd6;
    localparam logic [PC_W-1:0] P_PSTART = 4'd7;
    localparam logic [PC_W-1:0] P_SLOT   = 4'd8;
    localparam logic [PC_W-1:0] P_PEND   = 4'd9;
    localparam logic [PC_W-1:0] P_PLOOP  = 4'd10;
    localparam logic [PC_W-1:0] P_OVF    = 4'd11;
    localparam logic [PC_W-1:0] P_SHOW   = 4'd12;

    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        case (pc)
            // op entry points follow P_REG in op code order
            P_IDLE:   w = '{act: A_NONE,   jmp: J_DISPATCH,  target: P_REG};
            P_REG:    w = '{act: A_REG,    jmp: J_GOTO,      target: P_SHOW};
            P_UNREG:  w = '{act: A_UNREG,  jmp: J_GOTO,      target: P_SHOW};
            P_TIMER:  w = '{act: A_TINIT,  jmp: J_GOTO,      target: P_PTEST};
            P_READ:   w = '{act: A_READ,   jmp: J_GOTO,      target: P_SHOW};
            P_PTEST:  w = '{act: A_NONE,   jmp: J_CMP_GT,    target: P_SHOW};
            P_LTEST:  w = '{act: A_NONE,   jmp: J_PASS_LIM,  target: P_OVF};
            P_PSTART: w = '{act: A_PSTART, jmp: J_NEXT,      target: P_IDLE};
            P_SLOT:   w = '{act: A_SLOT,   jmp: J_SLOT_LOOP, target: P_IDLE};
            P_PEND:   w = '{act: A_NONE,   jmp: J_NO_CMP,    target: P_SHOW};
            P_PLOOP:  w = '{act: A_NONE,   jmp: J_GOTO,      target: P_PTEST};
            P_OVF:    w = '{act: A_OVF,    jmp: J_GOTO,      target: P_SHOW};
            P_SHOW:   w = '{act: A_SHOW,   jmp: J_OUT,       target: P_IDLE};
            default:  w = '{act: A_NONE,   jmp: J_GOTO,      target: P_IDLE};
        endcase
        return w;
    endfunction

    // one-hot release bit; slots at or above 8 have no bit
    function automatic logic [7:0] mask_bit(input logic [SLOT_W-1:0] i);
        logic [7:0] m;
        m = '0;
        for (int k = 0; k < 8; k++) begin
            m[k] = (int'(i) == k);
        end
        return m;
    endfunction

endpackage

`default_nettype wire

>>> design/periodic_task_release_timer.sv
// periodic task release timer: slot table, scan datapath and microcoded sequencer
// depends on ptrt_pkg (types, constants, control-store program)
//
//  channel   dir  handshake              tdata fields (low bit first)
//  s_axis    in   s_tvalid / s_tready    op, slot, phasing, period_raw, task_flags_in,
//                                        timer_value
//  m_axis    out  m_tvalid / m_tready    status, compare_value, released_mask,
//                                        activation_count, pass_overflow
//
//  register, unregister and read pass through their op step and then the show step
//  a timer event repeats scan passes while the compare value is not above the timer;
//  it ends early when a pass leaves the no-compare value and sets pass_overflow when it
//  stops at PASS_LIMIT; each pass walks the slot table one slot a cycle
//  reset empties the table and sets the compare value to zero
//  one item at a time; a new item is taken while a result waits in the output register
`default_nettype none

module periodic_task_release_timer (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // op, slot, phasing, period_raw, task_flags_in, timer_value, zero pad
    input  wire logic [ptrt_pkg::IN_W-1:0]  s_tdata,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    // status, compare_value, released_mask, activation_count, pass_overflow, zero pad
    output logic [ptrt_pkg::OUT_W-1:0]     m_tdata,
    output logic                           m_tvalid,
    input  wire logic                      m_tready
);
    import ptrt_pkg::*;

    localparam logic [7:0]        TASKS_B   = 8'(TASKS);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TASKS - 1);
    localparam logic [PASS_W-1:0] PASS_MAX  = PASS_W'(PASS_LIMIT);

    // slot table
    logic [7:0]  flags_reg [TASKS];
    logic [15:0] rel_reg   [TASKS];
    logic [15:0] per_reg   [TASKS];
    logic [15:0] act_reg   [TASKS];
    logic [15:0] cmp_reg, cmp_next;

    // sequencer
    logic [PC_W-1:0]   pc_reg, pc_next;
    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic [PASS_W-1:0] passes_reg, passes_next;
    ucode_t            uc;

    // captured item
    op_t         op_reg;
    logic [7:0]  slot_reg;
    logic [15:0] phasing_reg, period_raw_reg, timer_reg;
    logic [6:0]  task_flags_reg;

    // result under construction
    status_t     status_reg, status_next;
    logic [15:0] cnt_reg, cnt_next;
    logic [7:0]  mask_reg, mask_next;
    logic        ovf_reg, ovf_next;

    logic [OUT_W-1:0] out_data_reg, out_data_next;
    logic             out_valid_reg, out_valid_next;

    // datapath
    logic              s_accept, out_free, slot_oor, trig, due;
    logic [SLOT_W-1:0] sel_idx;
    logic [7:0]        rd_flags;
    logic [15:0]       rd_rel, rd_per, rd_act, rel_sum, rel_eff, ph_x4, per_x4, cmp_out;
    logic              flags_we, rel_we, per_we, act_we;
    logic [7:0]        flags_wd;
    logic [15:0]       rel_wd, per_wd, act_wd;

    assign uc       = ucode_rom(pc_reg);
    assign s_tready = (pc_reg == P_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // single table read port, shared by the scan and the addressed ops
    assign sel_idx  = (uc.act == A_SLOT) ? idx_reg : slot_reg[SLOT_W-1:0];
    assign rd_flags = flags_reg[sel_idx];
    assign rd_rel   = rel_reg[sel_idx];
    assign rd_per   = per_reg[sel_idx];
    assign rd_act   = act_reg[sel_idx];

    assign slot_oor = (slot_reg >= TASKS_B);
    assign ph_x4    = {phasing_reg[13:0], 2'b00};
    assign per_x4   = {period_raw_reg[13:0], 2'b00};
    assign trig     = rd_flags[TRIG_POS];
    assign due      = (rd_rel <= timer_reg);
    assign rel_sum  = rd_rel + rd_per;
    assign rel_eff  = due ? rel_sum : rd_rel;
    assign cmp_out  = (op_reg == OP_TIMER) ? cmp_reg : 16'd0;

    always_comb
    begin
        cmp_next       = cmp_reg;
        idx_next       = idx_reg;
        passes_next    = passes_reg;
        status_next    = status_reg;
        cnt_next       = cnt_reg;
        mask_next      = mask_reg;
        ovf_next       = ovf_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;
        flags_we       = 1'b0;
        rel_we         = 1'b0;
        per_we         = 1'b0;
        act_we         = 1'b0;
        flags_wd       = '0;
        rel_wd         = rel_sum;
        per_wd         = per_x4;
        act_wd         = rd_act + 16'd1;

        if (m_tvalid && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (s_accept)
        begin
            status_next = ST_OK;
            cnt_next    = '0;
            mask_next   = '0;
            ovf_next    = 1'b0;
        end

        case (uc.act)
            A_REG:
            begin
                if (slot_oor)
                begin
                    status_next = ST_BOUNDS;
                end
                else if (per_x4 == 16'd0)
                begin
                    status_next = ST_PARAM;
                end
                else if (rd_flags != 8'd0)
                begin
                    status_next = ST_BUSY;
                end
                else
                begin
                    rel_we   = 1'b1;
                    rel_wd   = ph_x4;
                    per_we   = 1'b1;
                    act_we   = 1'b1;
                    act_wd   = '0;
                    flags_we = 1'b1;
                    flags_wd = {1'b1, task_flags_reg};
                end
            end
            A_UNREG:
            begin
                if (slot_oor)
                begin
                    status_next = ST_BOUNDS;
                end
                else
                begin
                    flags_we = 1'b1;
                end
            end
            A_READ:
            begin
                if (slot_oor)
                begin
                    status_next = ST_BOUNDS;
                end
                else
                begin
                    cnt_next = rd_act;
                end
            end
            A_TINIT:
            begin
                passes_next = '0;
            end
            A_PSTART:
            begin
                passes_next = passes_reg + PASS_W'(1);
                cmp_next    = NO_COMPARE;
                idx_next    = '0;
            end
            A_SLOT:
            begin
                if (trig)
                begin
                    if (due)
                    begin
                        act_we    = 1'b1;
                        rel_we    = 1'b1;
                        mask_next = mask_reg | mask_bit(sel_idx);
                    end
                    if (rel_eff < cmp_reg)
                    begin
                        cmp_next = rel_eff;
                    end
                end
                if (idx_reg != LAST_SLOT)
                begin
                    idx_next = idx_reg + SLOT_W'(1);
                end
            end
            A_OVF:
            begin
                ovf_next = 1'b1;
            end
            A_SHOW:
            begin
                if (out_free)
                begin
                    out_data_next  = {5'b0, ovf_reg, cnt_reg, mask_reg, cmp_out, status_reg};
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // step counter and conditional jumps
    always_comb
    begin
        case (uc.jmp)
            J_NEXT:      pc_next = pc_reg + PC_W'(1);
            J_GOTO:      pc_next = uc.target;
            J_DISPATCH:  pc_next = s_accept ? uc.target + PC_W'(s_tdata[1:0]) : pc_reg;
            J_CMP_GT:    pc_next = (cmp_reg > timer_reg) ? uc.target : pc_reg + PC_W'(1);
            J_PASS_LIM:  pc_next = (passes_reg >= PASS_MAX) ? uc.target : pc_reg + PC_W'(1);
            J_SLOT_LOOP: pc_next = (idx_reg != LAST_SLOT) ? pc_reg : pc_reg + PC_W'(1);
            J_NO_CMP:    pc_next = (cmp_reg == NO_COMPARE) ? uc.target : pc_reg + PC_W'(1);
            J_OUT:       pc_next = out_free ? uc.target : pc_reg;
            default:     pc_next = P_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= P_IDLE;
            out_valid_reg <= 1'b0;
            cmp_reg       <= '0;
            for (int i = 0; i < TASKS; i++)
            begin
                flags_reg[i] <= '0;
                rel_reg[i]   <= '0;
                per_reg[i]   <= '0;
                act_reg[i]   <= '0;
            end
        end
        else
        begin
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
            cmp_reg       <= cmp_next;
            if (flags_we)
            begin
                flags_reg[sel_idx] <= flags_wd;
            end
            if (rel_we)
            begin
                rel_reg[sel_idx] <= rel_wd;
            end
            if (per_we)
            begin
                per_reg[sel_idx] <= per_wd;
            end
            if (act_we)
            begin
                act_reg[sel_idx] <= act_wd;
            end
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        passes_reg   <= passes_next;
        status_reg   <= status_next;
        cnt_reg      <= cnt_next;
        mask_reg     <= mask_next;
        ovf_reg      <= ovf_next;
        out_data_reg <= out_data_next;
        if (s_accept)
        begin
            op_reg         <= op_t'(s_tdata[1:0]);
            slot_reg       <= s_tdata[9:2];
            phasing_reg    <= s_tdata[25:10];
            period_raw_reg <= s_tdata[41:26];
            task_flags_reg <= s_tdata[48:42];
            timer_reg      <= s_tdata[64:49];
        end
    end

endmodule

`default_nettype wire

>>> sim/periodic_task_release_timer_tb.sv
`timescale 1ns / 100ps
// testbench for periodic_task_release_timer: drives register, unregister, timer and read
// words, predicts every reply from a software copy of the slot table; needs ptrt_pkg

module periodic_task_release_timer_tb;

    import ptrt_pkg::*;

    localparam int WATCH_LIMIT = 20000;
    localparam int TAIL_CYCLES = 250;
    localparam int N_RANDOM    = 500;

    typedef struct {
        op_t         op;
        logic [7:0]  slot;
        logic [15:0] phasing;
        logic [15:0] period_raw;
        logic [6:0]  flags;
        logic [15:0] timer_value;
        bit          hold;
        int          phase;
    } job_t;

    typedef struct {
        status_t     status;
        logic [15:0] compare_value;
        logic [7:0]  released_mask;
        logic [15:0] activation_count;
        logic        pass_overflow;
    } reply_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic [IN_W-1:0]    s_tdata = '0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [OUT_W-1:0]   m_tdata;
    logic               m_tvalid;
    logic               m_tready = 1'b0;

    periodic_task_release_timer u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    always #5 clk = ~clk;

    // software copy of the slot table
    logic [7:0]  t_flags    [TASKS];
    logic [15:0] t_release  [TASKS];
    logic [15:0] t_period   [TASKS];
    logic [15:0] t_deadline [TASKS];
    logic [15:0] t_acts     [TASKS];
    logic [15:0] t_compare;

    job_t   job_q[$];
    reply_t reply_q[$];
    job_t   cur_job;
    int     cur_phase = 0;
    logic [15:0] tnow = '0;

    int errors = 0;
    int replies_seen = 0;
    int n_op [4] = '{0, 0, 0, 0};
    int n_ovf = 0;
    int n_released = 0;
    int quiet_cycles = 0;

    function automatic reply_t table_step(input job_t j);
        reply_t      r;
        logic [15:0] ph;
        logic [15:0] per;
        int          passes;
        int          s;
        r = '{status: ST_OK, compare_value: '0, released_mask: '0,
              activation_count: '0, pass_overflow: 1'b0};
        s = int'(j.slot);
        case (j.op)
            OP_REGISTER: begin
                ph  = {j.phasing[13:0], 2'b00};
                per = {j.period_raw[13:0], 2'b00};
                if (s >= TASKS) r.status = ST_BOUNDS;
                else if (per == 16'd0) r.status = ST_PARAM;
                else if (t_flags[s] != 8'd0) r.status = ST_BUSY;
                else begin
                    t_release[s]  = ph;
                    t_period[s]   = per;
                    t_deadline[s] = ph + per;
                    t_acts[s]     = '0;
                    t_flags[s]    = {1'b1, j.flags};
                end
            end
            OP_UNREGISTER: begin
                if (s >= TASKS) r.status = ST_BOUNDS;
                else t_flags[s] = '0;
            end
            OP_TIMER: begin
                passes = 0;
                while (t_compare <= j.timer_value) begin
                    if (passes >= PASS_LIMIT) begin
                        r.pass_overflow = 1'b1;
                        break;
                    end
                    passes++;
                    t_compare = NO_COMPARE;
                    for (int i = 0; i < TASKS; i++) begin
                        if (t_flags[i][TRIG_POS]) begin
                            if (t_release[i] <= j.timer_value) begin
                                t_acts[i]    = t_acts[i] + 16'd1;
                                t_release[i] = t_release[i] + t_period[i];
                                if (i < 8) r.released_mask[i] = 1'b1;
                            end
                            if (t_release[i] < t_compare) t_compare = t_release[i];
                        end
                    end
                    if (t_compare == NO_COMPARE) break;
                end
                r.compare_value = t_compare;
            end
            default: begin
                if (s >= TASKS) r.status = ST_BOUNDS;
                else r.activation_count = t_acts[s];
            end
        endcase
        return r;
    endfunction

    function automatic void push_job(input op_t op, input logic [7:0] slot,
                                     input logic [15:0] ph, input logic [15:0] per,
                                     input logic [6:0] fl, input logic [15:0] tv,
                                     input bit hold, input int phase);
        job_t j;
        j = '{op: op, slot: slot, phasing: ph, period_raw: per, flags: fl,
              timer_value: tv, hold: hold, phase: phase};
        job_q.push_back(j);
    endfunction

    // mostly well-formed traffic: slots in range, small periods, timer moving forward
    function automatic job_t random_job(input int phase);
        job_t j;
        int   pick;
        j.hold  = 1'b0;
        j.phase = phase;
        pick    = $urandom_range(0, 99);
        if (pick < 30) j.op = OP_REGISTER;
        else if (pick < 42) j.op = OP_UNREGISTER;
        else if (pick < 78) j.op = OP_TIMER;
        else j.op = OP_READ;
        j.slot = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, TASKS - 1));
        j.flags = 7'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 60) j.period_raw = 16'($urandom_range(1, 64));
        else if (pick < 68) j.period_raw = 16'd0;
        else if (pick < 73) j.period_raw = ($urandom_range(0, 1) != 0) ? 16'h4000 : 16'hC000;
        else j.period_raw = 16'($urandom);
        if ($urandom_range(0, 1) != 0) j.phasing = (tnow >> 2) + 16'($urandom_range(0, 40));
        else j.phasing = 16'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            tnow = tnow + 16'($urandom_range(1, 300));
            j.timer_value = tnow;
        end else if (pick < 75) begin
            j.timer_value = 16'hFFFF;
        end else begin
            j.timer_value = 16'($urandom);
        end
        return j;
    endfunction

    // driver: next word from job_q, with a random gap before each outside the last phase
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                reply_q.push_back(table_step(cur_job));
                n_op[int'(cur_job.op)]++;
            end
            if (!s_tvalid || s_tready) begin
                if (job_q.size() > 0
                    && $urandom_range(0, 99) >= ((job_q[0].phase == 0) ? 29 :
                                                  (job_q[0].phase == 1) ? 50 : 0)
                    && (!job_q[0].hold || reply_q.size() == 0)) begin
                    cur_job = job_q.pop_front();
                    s_tvalid  <= 1'b1;
                    s_tdata   <= {7'd0, cur_job.timer_value, cur_job.flags,
                                  cur_job.period_raw, cur_job.phasing, cur_job.slot,
                                  cur_job.op};
                    cur_phase <= cur_job.phase;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endfunction

    // monitor: compare each reply word with the oldest prediction
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (reply_q.size() == 0) begin
                    $display("%0t: unexpected reply word, expected none, actual %h",
                             $time, m_tdata);
                    errors++;
                end else begin
                    reply_t w;
                    w = reply_q.pop_front();
                    replies_seen++;
                    if (w.pass_overflow) n_ovf++;
                    if (w.released_mask != 8'd0) n_released++;
                    check_field("status", 16'(w.status), 16'(m_tdata[1:0]));
                    check_field("compare_value", w.compare_value, m_tdata[17:2]);
                    check_field("released_mask", 16'(w.released_mask), 16'(m_tdata[25:18]));
                    check_field("activation_count", w.activation_count, m_tdata[41:26]);
                    check_field("pass_overflow", 16'(w.pass_overflow), 16'(m_tdata[42]));
                end
            end
            m_tready <= $urandom_range(0, 99) >= ((cur_phase == 0) ? 50 :
                                                  (cur_phase == 1) ? 29 : 0);
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCH_LIMIT) begin
                $display("%0t: timeout, %0d replies outstanding", $time, reply_q.size());
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        for (int i = 0; i < TASKS; i++) begin
            t_flags[i]    = '0;
            t_release[i]  = '0;
            t_period[i]   = '0;
            t_deadline[i] = '0;
            t_acts[i]     = '0;
        end
        t_compare = '0;

        // empty table, out of range slots, bad periods, busy slot
        push_job(OP_READ,       8'd0,   16'd0,    16'd0,    7'd0,    16'd0,    0, 0);
        push_job(OP_READ,       8'd255, 16'hFFFF, 16'hFFFF, 7'h7F,   16'hFFFF, 0, 0);
        push_job(OP_UNREGISTER, 8'd200, 16'd0,    16'd0,    7'd0,    16'd0,    0, 0);
        push_job(OP_REGISTER,   8'd8,   16'd0,    16'd1,    7'd0,    16'd0,    0, 0);
        push_job(OP_REGISTER,   8'd0,   16'd0,    16'd0,    7'd0,    16'd0,    0, 0);
        push_job(OP_REGISTER,   8'd0,   16'd5,    16'h4000, 7'd1,    16'd0,    0, 0);
        push_job(OP_REGISTER,   8'd0,   16'd0,    16'd1,    7'h7F,   16'd0,    0, 0);
        push_job(OP_REGISTER,   8'd0,   16'd3,    16'd2,    7'd0,    16'd0,    0, 0);
        push_job(OP_REGISTER,   8'd7,   16'hFFFF, 16'hFFFF, 7'd0,    16'd0,    0, 0);
        push_job(OP_REGISTER,   8'd3,   16'd10,   16'd25,   7'h55,   16'd0,    0, 0);
        push_job(OP_TIMER,      8'd0,   16'd0,    16'd0,    7'd0,    16'd0,    0, 0);
        push_job(OP_TIMER,      8'd0,   16'd0,    16'd0,    7'd0,    16'd3,    0, 0);
        // period four against a far timer runs out of passes
        push_job(OP_TIMER,      8'd0,   16'd0,    16'd0,    7'd0,    16'd100,  0, 0);
        push_job(OP_READ,       8'd0,   16'd0,    16'd0,    7'd0,    16'd0,    0, 0);
        push_job(OP_READ,       8'd3,   16'd0,    16'd0,    7'd0,    16'd0,    0, 0);
        push_job(OP_TIMER,      8'd0,   16'd0,    16'd0,    7'd0,    16'hFFFF, 0, 0);
        push_job(OP_READ,       8'd7,   16'd0,    16'd0,    7'd0,    16'd0,    0, 0);
        push_job(OP_UNREGISTER, 8'd0,   16'd0,    16'd0,    7'd0,    16'd0,    0, 0);
        push_job(OP_READ,       8'd0,   16'd0,    16'd0,    7'd0,    16'd0,    0, 0);
        push_job(OP_REGISTER,   8'd0,   16'd100,  16'd7,    7'h2A,   16'd0,    0, 0);
        push_job(OP_UNREGISTER, 8'd3,   16'd0,    16'd0,    7'd0,    16'd0,    0, 0);
        push_job(OP_UNREGISTER, 8'd7,   16'd0,    16'd0,    7'd0,    16'd0,    0, 0);
        push_job(OP_UNREGISTER, 8'd0,   16'd0,    16'd0,    7'd0,    16'd0,    0, 0);
        // nothing active: a full-scale timer ends on the no-compare value
        push_job(OP_TIMER,      8'd0,   16'd0,    16'd0,    7'd0,    16'hFFFF, 0, 0);
        push_job(OP_READ,       8'd5,   16'd0,    16'd0,    7'd0,    16'd0,    0, 0);

        for (int n = 0; n < N_RANDOM; n++) begin
            job_t j;
            j = random_job((n < N_RANDOM / 3) ? 0 : (n < 2 * N_RANDOM / 3) ? 1 : 2);
            // drain all replies before each new traffic phase
            if (n == N_RANDOM / 3 || n == 2 * N_RANDOM / 3) j.hold = 1'b1;
            job_q.push_back(j);
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (job_q.size() > 0 || s_tvalid || reply_q.size() > 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (reply_q.size() != 0) begin
            $display("%0t: %0d replies never arrived", $time, reply_q.size());
            errors++;
        end
        $display("covered %0d register, %0d unregister, %0d timer, %0d read words",
                 n_op[0], n_op[1], n_op[2], n_op[3]);
        $display("%0d replies checked, %0d with releases, %0d pass overflows, %0d mismatches",
                 replies_seen, n_released, n_ovf, errors);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
